### src/xref_stream_entry_decoder_core_macros.svh
// assertion macros shared by the cross-reference entry decoder modules
`ifndef XREF_STREAM_ENTRY_DECODER_CORE_MACROS_SVH
`define XREF_STREAM_ENTRY_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define XSED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// expression must never be true outside reset
`define XSED_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define XSED_ASSERT(lbl, prop, msg)
`define XSED_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### src/xsed_pkg.sv
// shared types, constants and helpers of the cross-reference entry decoder
package xsed_pkg;

	localparam int BYTE_W   = 8;
	localparam int VAL_W    = 64;
	localparam int WIDTH_W  = 4;
	localparam int POS_W    = 5;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// item queue between front and back
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;

	localparam logic [WIDTH_W-1:0] MAX_FIELD_BYTES = 4'd8;

	// register reset values
	localparam logic [WIDTH_W-1:0] RST_TYPE_WIDTH   = 4'd1;
	localparam logic [WIDTH_W-1:0] RST_FIRST_WIDTH  = 4'd4;
	localparam logic [WIDTH_W-1:0] RST_SECOND_WIDTH = 4'd2;

	// register indexes
	localparam logic [1:0] REG_TYPE_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FIRST_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SECOND_WIDTH = 2'd2;

	typedef enum logic [2:0] {
		KIND_FREE        = 3'd0,
		KIND_NORMAL      = 3'd1,
		KIND_COMPRESSED  = 3'd2,
		KIND_UNKNOWN     = 3'd3,
		KIND_TRUNCATED   = 3'd4,
		KIND_ZERO_WIDTHS = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		FLD_TYPE   = 2'd0,
		FLD_FIRST  = 2'd1,
		FLD_SECOND = 2'd2
	} field_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] type_width;
		logic [WIDTH_W-1:0] first_width;
		logic [WIDTH_W-1:0] second_width;
	} widths_t;

	// one classified byte, handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		field_t            field;
		logic              drop;
		logic              complete;
		logic              trunc;
		logic              zero;
		logic              last_byte;
		logic              type_dflt;
	} item_t;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
		return (w > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : w;
	endfunction

endpackage

### src/xsed_front.sv
// front end: tracks the byte position and classifies each accepted byte
`include "xref_stream_entry_decoder_core_macros.svh"
module xsed_front import xsed_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  widths_t           widths,
	output logic              item_valid,
	output item_t             item
);

	logic [POS_W-1:0]   pos_q;
	logic [WIDTH_W-1:0] tw, fw, sw;
	logic [POS_W-1:0]   total, type_end, field_end, pos_eff, pos_inc;
	logic               accept, drop, zero, complete;

	// entry geometry from clamped widths
	always_comb begin
		tw        = clamp_width(widths.type_width);
		fw        = clamp_width(widths.first_width);
		sw        = clamp_width(widths.second_width);
		type_end  = POS_W'(tw);
		field_end = POS_W'(tw) + POS_W'(fw);
		total     = field_end + POS_W'(sw);
		zero      = (total == '0);
		drop      = !zero && (pos_q >= total);
		pos_eff   = drop ? '0 : pos_q;
		pos_inc   = pos_eff + POS_W'(1);
		complete  = !zero && (pos_inc == total);
	end

	// classify the byte
	always_comb begin
		item.data_byte = data_byte;
		if (pos_eff < type_end) begin
			item.field = FLD_TYPE;
		end else if (pos_eff < field_end) begin
			item.field = FLD_FIRST;
		end else begin
			item.field = FLD_SECOND;
		end
		item.drop      = drop;
		item.complete  = complete;
		item.trunc     = !zero && !complete && last_byte;
		item.zero      = zero;
		item.last_byte = last_byte;
		item.type_dflt = (tw == '0);
	end

	assign accept     = push && !full;
	assign item_valid = accept;

	// position within the current entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (zero || complete || last_byte) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc;
			end
		end
	end

	`XSED_ASSERT_NEVER(a_pos_range, pos_q > POS_W'(24), "byte position beyond largest entry")

endmodule

### src/xsed_queue.sv
// short item queue that decouples the front end from the back end
`include "xref_stream_entry_decoder_core_macros.svh"
module xsed_queue import xsed_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	output logic  rd_valid,
	output item_t rd_item,
	input  logic  rd_en
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	`XSED_ASSERT_NEVER(a_q_overfill, cnt_q > QCNT_W'(QDEPTH), "item queue count beyond depth")
	`XSED_ASSERT(a_q_ptr_gap, (QPTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[QPTR_W-1:0]), "queue pointers disagree with count")

endmodule

### src/xsed_back.sv
// back end: assembles field values and emits entry results
`include "xref_stream_entry_decoder_core_macros.svh"
module xsed_back import xsed_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output logic [2:0]       entry_kind,
	output logic [VAL_W-1:0] type_value,
	output logic [VAL_W-1:0] first_value,
	output logic [VAL_W-1:0] second_value,
	output logic             stream_done
);

	logic [VAL_W-1:0] type_acc_q, first_acc_q, second_acc_q;
	logic [VAL_W-1:0] type_sh, first_sh, second_sh, tv;
	logic             res_valid_q, take, emits;
	kind_t            kind_q, kind;
	logic [VAL_W-1:0] type_q, first_q, second_q;
	logic             done_q;

	// shift the byte into the selected field
	always_comb begin
		type_sh   = q_item.drop ? '0 : type_acc_q;
		first_sh  = q_item.drop ? '0 : first_acc_q;
		second_sh = q_item.drop ? '0 : second_acc_q;
		case (q_item.field)
			FLD_TYPE:   type_sh   = {type_sh[VAL_W-BYTE_W-1:0], q_item.data_byte};
			FLD_FIRST:  first_sh  = {first_sh[VAL_W-BYTE_W-1:0], q_item.data_byte};
			FLD_SECOND: second_sh = {second_sh[VAL_W-BYTE_W-1:0], q_item.data_byte};
			default:    second_sh = {second_sh[VAL_W-BYTE_W-1:0], q_item.data_byte};
		endcase
		tv = q_item.type_dflt ? VAL_W'(1) : type_sh;
	end

	// kind of a completed entry
	always_comb begin
		if (tv == VAL_W'(0)) begin
			kind = KIND_FREE;
		end else if (tv == VAL_W'(1)) begin
			kind = KIND_NORMAL;
		end else if (tv == VAL_W'(2)) begin
			kind = KIND_COMPRESSED;
		end else begin
			kind = KIND_UNKNOWN;
		end
	end

	assign emits = q_item.zero || q_item.complete || q_item.trunc;
	assign take  = q_valid && (!res_valid_q || pop);
	assign q_pop = take;

	// accumulators and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_acc_q   <= '0;
			first_acc_q  <= '0;
			second_acc_q <= '0;
			res_valid_q  <= 1'b0;
		end else if (take) begin
			if (emits) begin
				type_acc_q   <= '0;
				first_acc_q  <= '0;
				second_acc_q <= '0;
				res_valid_q  <= 1'b1;
			end else begin
				type_acc_q   <= type_sh;
				first_acc_q  <= first_sh;
				second_acc_q <= second_sh;
				res_valid_q  <= res_valid_q && !pop;
			end
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && emits) begin
			if (q_item.zero) begin
				kind_q   <= KIND_ZERO_WIDTHS;
				type_q   <= VAL_W'(1);
				first_q  <= '0;
				second_q <= '0;
				done_q   <= q_item.last_byte;
			end else if (q_item.complete) begin
				kind_q   <= kind;
				type_q   <= tv;
				first_q  <= first_sh;
				second_q <= second_sh;
				done_q   <= q_item.last_byte;
			end else begin
				kind_q   <= KIND_TRUNCATED;
				type_q   <= tv;
				first_q  <= first_sh;
				second_q <= second_sh;
				done_q   <= 1'b1;
			end
		end
	end

	assign empty        = !res_valid_q;
	assign entry_kind   = kind_q;
	assign type_value   = type_q;
	assign first_value  = first_q;
	assign second_value = second_q;
	assign stream_done  = done_q;

	`XSED_ASSERT(a_trunc_done, (res_valid_q && kind_q == KIND_TRUNCATED) |-> done_q, "truncated entry without end of stream")
	`XSED_ASSERT(a_zero_vals, (res_valid_q && kind_q == KIND_ZERO_WIDTHS) |-> (type_q == VAL_W'(1) && first_q == '0 && second_q == '0), "zero-width result with field data")

endmodule

### src/xref_stream_entry_decoder_core.sv
// top level of the cross-reference stream entry decoder
//
// Bytes of decoded cross-reference stream content go in through a queue-style
// port: data_byte and last_byte are taken at a clock edge with push high and
// full low. Results come out the same way: while empty is low the oldest
// result sits on entry_kind, type_value, first_value, second_value and
// stream_done, and pop takes it. Three field widths (0 to 8 bytes each, larger
// values count as 8) are set over the APB port at 0x0, 0x4 and 0x8; write
// them only while the block is idle.
// The front end classifies a byte as it is taken and writes it into the queue;
// the back end folds it in as it takes it from the queue, while the result
// register is free or being popped, and an entry that this completes sets
// empty low. One byte is taken per cycle as long as results are popped.
// When pop stays low the result register holds, the four-item queue between
// front and back fills, and full rises. Reset clears the position, the
// accumulators, the queue and the result, and loads widths 1, 4 and 2.
module xref_stream_entry_decoder_core import xsed_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               last_byte,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         entry_kind,
	output logic [VAL_W-1:0]   type_value,
	output logic [VAL_W-1:0]   first_value,
	output logic [VAL_W-1:0]   second_value,
	output logic               stream_done,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	widths_t    widths_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       item_valid;
	item_t      item;
	logic       q_valid, q_pop;
	item_t      q_item;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widths_q.type_width   <= RST_TYPE_WIDTH;
			widths_q.first_width  <= RST_FIRST_WIDTH;
			widths_q.second_width <= RST_SECOND_WIDTH;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TYPE_WIDTH:   widths_q.type_width   <= pwdata[WIDTH_W-1:0];
				REG_FIRST_WIDTH:  widths_q.first_width  <= pwdata[WIDTH_W-1:0];
				REG_SECOND_WIDTH: widths_q.second_width <= pwdata[WIDTH_W-1:0];
				default:          widths_q              <= widths_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_TYPE_WIDTH:   prdata = PDATA_W'(widths_q.type_width);
			REG_FIRST_WIDTH:  prdata = PDATA_W'(widths_q.first_width);
			REG_SECOND_WIDTH: prdata = PDATA_W'(widths_q.second_width);
			default:          prdata = '0;
		endcase
	end

	xsed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.widths     (widths_q),
		.item_valid (item_valid),
		.item       (item)
	);

	xsed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (item_valid),
		.wr_item  (item),
		.full     (full),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_en    (q_pop)
	);

	xsed_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.entry_kind   (entry_kind),
		.type_value   (type_value),
		.first_value  (first_value),
		.second_value (second_value),
		.stream_done  (stream_done)
	);

endmodule
